// File: src/assert_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is high.
`define APQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define APQ_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/apq_pkg.sv
package apq_pkg;

   localparam int CODE_W = 16;
   localparam int AGE_W  = 14;
   localparam int PRIO_W = 3;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_AGE     = 2'd2
   } op_type;

   localparam logic [1:0] CAT_FIRST  = 2'd0;
   localparam logic [1:0] CAT_SECOND = 2'd1;

   localparam logic [PRIO_W-1:0] PRIO_TOP     = 3'd5;
   localparam logic [PRIO_W-1:0] PRIO_SECOND  = 3'd4;
   localparam logic [PRIO_W-1:0] PRIO_LOW     = 3'd1;
   localparam logic [PRIO_W-1:0] PRIO_AGE_MIN = 3'd2;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [AGE_W-1:0]  years;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // Broadcast to every cell and to the tally for one step.
   typedef struct packed {
      logic              insert;
      logic              extract;
      logic              age_up;
      logic [PRIO_W-1:0] prio;
      logic [CODE_W-1:0] code;
      logic [AGE_W-1:0]  years;
   } cell_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } status_type;

endpackage

// File: src/apq_cell.sv
`include "assert_macros.svh"

module apq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  apq_pkg::cell_ctl_type ctl,
   input  apq_pkg::entry_type    left,
   input  logic                  left_ge,
   input  apq_pkg::entry_type    right,
   output apq_pkg::entry_type    entry,
   output logic                  ge
);
   import apq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Holds an entry that stays ahead of a new word of priority ctl.prio.
   assign ge    = entry_ff.valid && (entry_ff.prio >= ctl.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!ge) begin
            if (left_ge) begin
               entry_in.valid = 1'b1;
               entry_in.code  = ctl.code;
               entry_in.years = ctl.years;
               entry_in.prio  = ctl.prio;
            end else begin
               entry_in = left;
            end
         end
      end else if (ctl.extract) begin
         entry_in = right;
      end else if (ctl.age_up) begin
         if (entry_ff.prio >= PRIO_AGE_MIN && entry_ff.prio < PRIO_TOP) begin
            entry_in.prio = entry_ff.prio + PRIO_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   `APQ_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !entry_ff.valid, "cell valid after reset")
   `APQ_ASSERT(a_prio_legal, clock, reset, entry_ff.valid |-> (entry_ff.prio == PRIO_LOW || entry_ff.prio == PRIO_SECOND || entry_ff.prio == PRIO_TOP), "cell holds illegal priority")
   `APQ_ASSERT(a_age_keeps_fill, clock, reset, ctl.age_up |=> $stable(entry_ff.valid), "aging moved a word")

endmodule

// File: src/apq_tally.sv
`include "assert_macros.svh"

module apq_tally #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  apq_pkg::cell_ctl_type        ctl,
   input  logic [apq_pkg::PRIO_W-1:0]   head_prio,
   output logic [CW-1:0]                fill,
   output logic [CW-1:0]                top,
   output apq_pkg::status_type          status
);
   import apq_pkg::*;

   // Only priorities 1, 4 and 5 ever exist, so two counters cover aging.
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] second_ff, second_in;

   always_comb begin
      fill_in   = fill_ff;
      top_in    = top_ff;
      second_in = second_ff;
      if (ctl.insert) begin
         fill_in = fill_ff + CW'(1);
         if (ctl.prio == PRIO_TOP) begin
            top_in = top_ff + CW'(1);
         end
         if (ctl.prio == PRIO_SECOND) begin
            second_in = second_ff + CW'(1);
         end
      end else if (ctl.extract) begin
         fill_in = fill_ff - CW'(1);
         if (head_prio == PRIO_TOP) begin
            top_in = top_ff - CW'(1);
         end
         if (head_prio == PRIO_SECOND) begin
            second_in = second_ff - CW'(1);
         end
      end else if (ctl.age_up) begin
         top_in    = top_ff + second_ff;
         second_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         top_ff    <= '0;
         second_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         top_ff    <= top_in;
         second_ff <= second_in;
      end
   end

   assign fill         = fill_ff;
   assign top          = top_ff;
   assign status.full  = (fill_ff == CW'(CAPACITY));
   assign status.empty = (fill_ff == '0);

   `APQ_ASSERT(a_tally_bound, clock, reset, ((CW+1)'(top_ff) + (CW+1)'(second_ff)) <= (CW+1)'(fill_ff), "priority counts exceed fill")
   `APQ_ASSERT(a_no_overfill, clock, reset, fill_ff <= CW'(CAPACITY), "fill beyond capacity")
   `APQ_ASSERT(a_age_clears, clock, reset, ctl.age_up && !ctl.insert && !ctl.extract |=> second_ff == '0, "aging left priority-4 entries")

endmodule

// File: src/aging_priority_queue.sv
// Sorted priority queue of up to CAPACITY words, held in a row of cells with the highest
// priority at the head. Each request (insert, extract, age) is applied to the whole row
// together: insert compares the new priority in every cell at once and shifts the tail right by
// one, extract shifts every cell left by one, age bumps priorities 2..4 in place. One response
// word is registered per request; a new request is taken in the cycle the previous response
// leaves, so the queue sustains one request per clock as long as rsp_stall stays low. The
// response is presented in the cycle after the request is taken. Equal priorities leave in
// arrival order, with words aged up to 5 behind words already at 5. top_count and fill_level
// come from running counters, not a scan of the row, and report the state after the step.
`include "assert_macros.svh"

module aging_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [apq_pkg::CODE_W-1:0]    req_patient_code,
   input  logic [apq_pkg::AGE_W-1:0]     req_patient_age,
   input  logic [1:0]                    req_category,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_out_valid,
   output logic [apq_pkg::CODE_W-1:0]    rsp_out_code,
   output logic [apq_pkg::AGE_W-1:0]     rsp_out_age,
   output logic [apq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic                          rsp_was_empty,
   output logic                          rsp_insert_rejected,
   output logic [4:0]                    rsp_top_count,
   output logic [4:0]                    rsp_fill_level
);
   import apq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   entry_type              chain [CAPACITY];
   logic [CAPACITY-1:0]    ge;
   cell_ctl_type           ctl;
   status_type             status;
   logic [CW-1:0]          fill;
   logic [CW-1:0]          top;
   logic                   accept;

   logic                   rsp_valid_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]      out_code_ff, out_code_in;
   logic [AGE_W-1:0]       out_age_ff, out_age_in;
   logic [PRIO_W-1:0]      out_prio_ff, out_prio_in;
   logic                   was_empty_ff, was_empty_in;
   logic                   rejected_ff, rejected_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.insert  = 1'b0;
      ctl.extract = 1'b0;
      ctl.age_up  = 1'b0;
      ctl.code    = req_patient_code;
      ctl.years   = req_patient_age;
      case (req_category)
         CAT_FIRST:  ctl.prio = PRIO_TOP;
         CAT_SECOND: ctl.prio = PRIO_SECOND;
         default:    ctl.prio = PRIO_LOW;
      endcase

      out_valid_in = 1'b0;
      out_code_in  = '0;
      out_age_in   = '0;
      out_prio_in  = '0;
      was_empty_in = 1'b0;
      rejected_in  = 1'b0;

      case (req_operation)
         OP_INSERT: begin
            ctl.insert  = accept && !status.full;
            rejected_in = status.full;
         end
         OP_EXTRACT: begin
            ctl.extract  = accept && !status.empty;
            was_empty_in = status.empty;
            if (!status.empty) begin
               out_valid_in = 1'b1;
               out_code_in  = chain[0].code;
               out_age_in   = chain[0].years;
               out_prio_in  = chain[0].prio;
            end
         end
         OP_AGE: begin
            ctl.age_up = accept;
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_ge;

      if (i == 0) begin : g_head
         assign left_e  = '0;
         assign left_ge = 1'b1;
      end else begin : g_mid
         assign left_e  = chain[i-1];
         assign left_ge = ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_body
         assign right_e = chain[i+1];
      end

      apq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .left    (left_e),
         .left_ge (left_ge),
         .right   (right_e),
         .entry   (chain[i]),
         .ge      (ge[i])
      );
   end

   apq_tally #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_tally (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_prio (chain[0].prio),
      .fill      (fill),
      .top       (top),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_valid_ff <= out_valid_in;
         out_code_ff  <= out_code_in;
         out_age_ff   <= out_age_in;
         out_prio_ff  <= out_prio_in;
         was_empty_ff <= was_empty_in;
         rejected_ff  <= rejected_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_valid       = out_valid_ff;
   assign rsp_out_code        = out_code_ff;
   assign rsp_out_age         = out_age_ff;
   assign rsp_out_priority    = out_prio_ff;
   assign rsp_was_empty       = was_empty_ff;
   assign rsp_insert_rejected = rejected_ff;
   // counters only move on accept, so these hold while the response waits
   assign rsp_top_count       = 5'(top);
   assign rsp_fill_level      = 5'(fill);

   `APQ_ASSERT(a_full_matches_tail, clock, reset, status.full == chain[CAPACITY-1].valid, "fill count disagrees with tail cell")
   `APQ_ASSERT(a_empty_matches_head, clock, reset, status.empty == !chain[0].valid, "fill count disagrees with head cell")

   for (genvar j = 1; j < CAPACITY; j++) begin : g_order
      `APQ_ASSERT(a_sorted, clock, reset, chain[j].valid |-> (chain[j-1].valid && chain[j-1].prio >= chain[j].prio), "row out of priority order")
   end

endmodule
